// ===== rtl/core/mwrd_pkg.sv =====
// Shared types, codes and helper functions of the masked write record decoder.
// Used by the front, queue, back and top modules; depends on nothing else.
`default_nettype none

package mwrd_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_RECORDS_DEF = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Fixed field widths.
  localparam int unsigned REC_W = 6;

  // Record layout.
  localparam logic [3:0] POS_LAST = 4'd15;
  localparam logic [3:0] TYPE_MAX = 4'd6;

  // Operation kinds.
  localparam logic [2:0] OP_WRITE = 3'd0;

  // Error codes.
  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_SIZE        = 4'd1;
  localparam logic [3:0] ERR_COUNT       = 4'd2;
  localparam logic [3:0] ERR_RESERVED    = 4'd3;
  localparam logic [3:0] ERR_TYPE        = 4'd4;
  localparam logic [3:0] ERR_MASK        = 4'd5;
  localparam logic [3:0] ERR_ADDRESS     = 4'd6;
  localparam logic [3:0] ERR_NO_FOLLOWER = 4'd7;
  localparam logic [3:0] ERR_CHAINED     = 4'd8;

  // Byte masks that a condition can be narrowed to.
  localparam logic [3:0] MASK_LANE0 = 4'h1;
  localparam logic [3:0] MASK_LANE1 = 4'h2;
  localparam logic [3:0] MASK_LANE2 = 4'h4;
  localparam logic [3:0] MASK_LANE3 = 4'h8;
  localparam logic [3:0] MASK_LOW   = 4'h3;
  localparam logic [3:0] MASK_HIGH  = 4'hC;
  localparam logic [3:0] MASK_FULL  = 4'hF;

  // One job handed from the front to the back: an error, or one write
  // record, possibly preceded by the condition record held before it.
  typedef struct packed {
    logic                   is_error;
    logic [3:0]             err_code;
    logic [REC_W-1:0]       rec_total;
    logic                   final_rec;
    logic                   cmp_warn;
    logic                   cond_valid;
    logic [2:0]             cond_type;
    logic [3:0]             cond_mask;
    logic [27:0]            cond_addr;
    logic [31:0]            cond_value;
    logic [3:0]             wr_mask;
    logic [27:0]            wr_addr;
    logic [31:0]            wr_value;
  } mwrd_job_t;

  // One result beat.
  typedef struct packed {
    logic [2:0]             op_kind;
    logic [27:0]            op_address;
    logic [2:0]             op_width;
    logic [31:0]            op_value;
    logic                   has_mask;
    logic [31:0]            compare_mask;
    logic [2:0]             cond_span;
    logic [3:0]             error_code;
    logic                   compare_warning;
    logic                   entry_done;
    logic [REC_W-1:0]       record_total;
    logic                   last_result;
  } mwrd_result_t;

  // Width in bytes of the write that starts at a set lane.
  function automatic logic [2:0] lane_width(input logic [3:0] mask, input logic [1:0] lane);
    logic [3:0] pair;
    pair = (mask >> lane) & 4'b0011;
    if (lane == 2'd0 && mask == MASK_FULL) begin
      return 3'd4;
    end
    if ((lane == 2'd0 || lane == 2'd2) && pair == 4'b0011) begin
      return 3'd2;
    end
    return 3'd1;
  endfunction

  // Lowest set lane at or above the given lane.
  function automatic logic [1:0] first_lane(input logic [3:0] mask, input logic [1:0] from);
    logic [1:0] r;
    r = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (mask[i] && 2'(i) >= from) begin
        r = 2'(i);
      end
    end
    return r;
  endfunction

  // Number of writes a byte mask splits into.
  function automatic logic [2:0] count_writes(input logic [3:0] mask);
    logic [2:0] n;
    logic [1:0] skip;
    n    = 3'd0;
    skip = 2'd0;
    for (int l = 0; l < 4; l++) begin
      if (skip != 2'd0) begin
        skip = skip - 2'd1;
      end else if (mask[l]) begin
        n    = n + 3'd1;
        skip = 2'(lane_width(mask, 2'(l)) - 3'd1);
      end
    end
    return n;
  endfunction

  // Byte mask expanded to a bit mask.
  function automatic logic [31:0] expand_mask(input logic [3:0] mask);
    logic [31:0] r;
    r = 32'd0;
    for (int l = 0; l < 4; l++) begin
      r[l*8 +: 8] = {8{mask[l]}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mwrd_front.sv =====
// Front part of the masked write record decoder: assembles records, checks them
// and pushes one job per write record, with its held condition, or per error. Depends on mwrd_pkg.
`default_nettype none

module mwrd_front #(
  parameter int unsigned MAX_RECORDS = mwrd_pkg::MAX_RECORDS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic [7:0]         data_byte_i,
  input  wire logic               last_byte_i,
  output logic                    in_stall_o,
  input  wire logic               job_full_i,
  output logic                    job_push_o,
  output mwrd_pkg::mwrd_job_t     job_o
);

  localparam logic [mwrd_pkg::REC_W-1:0] MaxRec = mwrd_pkg::REC_W'(MAX_RECORDS);

  // Control state.
  logic [3:0]                  pos_q, pos_d;
  logic [mwrd_pkg::REC_W-1:0]  records_q, records_d;
  logic                        held_valid_q, held_valid_d;
  logic                        cmp_nz_q, cmp_nz_d;
  logic                        cmp_seen_q, cmp_seen_d;
  logic                        discard_q, discard_d;

  // Record payload.
  logic [7:0]   flags_lo_q, flags_lo_d;
  logic         reserved_q, reserved_d;
  logic [27:0]  addr_q, addr_d;
  logic         addr_hi_q, addr_hi_d;
  logic [23:0]  value_q, value_d;
  logic [2:0]   held_type_q, held_type_d;
  logic [3:0]   held_mask_q, held_mask_d;
  logic [27:0]  held_addr_q, held_addr_d;
  logic [31:0]  held_value_q, held_value_d;

  logic                        accept;
  logic [3:0]                  type_w;
  logic [3:0]                  mask_w;
  logic                        rec_full;
  logic [mwrd_pkg::REC_W-1:0]  rec_inc;
  logic [3:0]                  rec_err;
  logic [31:0]                 value_full;
  logic                        cmp_seen_n;
  logic                        byte_nz;

  assign in_stall_o = job_full_i;
  assign accept     = in_valid_i & ~job_full_i;
  assign type_w     = flags_lo_q[3:0];
  assign mask_w     = flags_lo_q[7:4];
  assign rec_full   = records_q >= MaxRec;
  assign rec_inc    = records_q + mwrd_pkg::REC_W'(1);
  assign value_full = {data_byte_i, value_q};
  assign cmp_seen_n = cmp_seen_q | cmp_nz_q;
  assign byte_nz    = data_byte_i != 8'd0;

  // Check order: count, reserved, type, mask, address, chained, no follower.
  always_comb begin
    if (rec_full) begin
      rec_err = mwrd_pkg::ERR_COUNT;
    end else if (reserved_q) begin
      rec_err = mwrd_pkg::ERR_RESERVED;
    end else if (type_w > mwrd_pkg::TYPE_MAX) begin
      rec_err = mwrd_pkg::ERR_TYPE;
    end else if (mask_w == 4'd0) begin
      rec_err = mwrd_pkg::ERR_MASK;
    end else if (addr_hi_q || addr_q[1:0] != 2'd0) begin
      rec_err = mwrd_pkg::ERR_ADDRESS;
    end else if (held_valid_q && type_w != 4'd0) begin
      rec_err = mwrd_pkg::ERR_CHAINED;
    end else if (!held_valid_q && type_w != 4'd0 && last_byte_i) begin
      rec_err = mwrd_pkg::ERR_NO_FOLLOWER;
    end else begin
      rec_err = mwrd_pkg::ERR_NONE;
    end
  end

  always_comb begin
    pos_d        = pos_q;
    records_d    = records_q;
    held_valid_d = held_valid_q;
    cmp_nz_d     = cmp_nz_q;
    cmp_seen_d   = cmp_seen_q;
    discard_d    = discard_q;
    flags_lo_d   = flags_lo_q;
    reserved_d   = reserved_q;
    addr_d       = addr_q;
    addr_hi_d    = addr_hi_q;
    value_d      = value_q;
    held_type_d  = held_type_q;
    held_mask_d  = held_mask_q;
    held_addr_d  = held_addr_q;
    held_value_d = held_value_q;
    job_push_o   = 1'b0;
    job_o        = '0;

    if (accept) begin
      if (discard_q) begin
        if (last_byte_i) begin
          discard_d = 1'b0;
        end
      end else begin
        case (pos_q[3:2])
          2'd0: begin
            case (pos_q[1:0])
              2'd0:    flags_lo_d = data_byte_i;
              2'd1:    reserved_d = byte_nz;
              default: reserved_d = reserved_q | byte_nz;
            endcase
          end
          2'd1: begin
            case (pos_q[1:0])
              2'd0:    addr_d[7:0]   = data_byte_i;
              2'd1:    addr_d[15:8]  = data_byte_i;
              2'd2:    addr_d[23:16] = data_byte_i;
              default: begin
                addr_d[27:24] = data_byte_i[3:0];
                addr_hi_d     = data_byte_i[7:4] != 4'd0;
              end
            endcase
          end
          2'd2: begin
            if (byte_nz) begin
              cmp_nz_d = 1'b1;
            end
          end
          default: begin
            case (pos_q[1:0])
              2'd0:    value_d[7:0]   = data_byte_i;
              2'd1:    value_d[15:8]  = data_byte_i;
              2'd2:    value_d[23:16] = data_byte_i;
              default: value_d        = value_q;
            endcase
          end
        endcase

        if (pos_q != mwrd_pkg::POS_LAST) begin
          pos_d = pos_q + 4'd1;
          if (last_byte_i) begin
            // Entry ends inside a record.
            job_push_o       = 1'b1;
            job_o.is_error   = 1'b1;
            job_o.err_code   = mwrd_pkg::ERR_SIZE;
            job_o.rec_total  = records_q;
            pos_d            = 4'd0;
            records_d        = '0;
            held_valid_d     = 1'b0;
            cmp_nz_d         = 1'b0;
            cmp_seen_d       = 1'b0;
          end
        end else begin
          pos_d = 4'd0;
          if (rec_err != mwrd_pkg::ERR_NONE) begin
            job_push_o      = 1'b1;
            job_o.is_error  = 1'b1;
            job_o.err_code  = rec_err;
            job_o.rec_total = rec_full ? records_q : rec_inc;
            records_d       = '0;
            held_valid_d    = 1'b0;
            cmp_nz_d        = 1'b0;
            cmp_seen_d      = 1'b0;
            discard_d       = ~last_byte_i;
          end else begin
            records_d  = rec_inc;
            cmp_nz_d   = 1'b0;
            cmp_seen_d = cmp_seen_n;
            if (held_valid_q || type_w == 4'd0) begin
              job_push_o       = 1'b1;
              job_o.cond_valid = held_valid_q;
              job_o.cond_type  = held_type_q;
              job_o.cond_mask  = held_mask_q;
              job_o.cond_addr  = held_addr_q;
              job_o.cond_value = held_value_q;
              job_o.wr_mask    = mask_w;
              job_o.wr_addr    = addr_q;
              job_o.wr_value   = value_full;
              held_valid_d     = 1'b0;
              if (last_byte_i) begin
                job_o.final_rec = 1'b1;
                job_o.rec_total = rec_inc;
                job_o.cmp_warn  = cmp_seen_n;
                records_d       = '0;
                cmp_seen_d      = 1'b0;
              end
            end else begin
              held_valid_d = 1'b1;
              held_type_d  = type_w[2:0];
              held_mask_d  = mask_w;
              held_addr_d  = addr_q;
              held_value_d = value_full;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= 4'd0;
      records_q    <= '0;
      held_valid_q <= 1'b0;
      cmp_nz_q     <= 1'b0;
      cmp_seen_q   <= 1'b0;
      discard_q    <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      records_q    <= records_d;
      held_valid_q <= held_valid_d;
      cmp_nz_q     <= cmp_nz_d;
      cmp_seen_q   <= cmp_seen_d;
      discard_q    <= discard_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flags_lo_q   <= flags_lo_d;
    reserved_q   <= reserved_d;
    addr_q       <= addr_d;
    addr_hi_q    <= addr_hi_d;
    value_q      <= value_d;
    held_type_q  <= held_type_d;
    held_mask_q  <= held_mask_d;
    held_addr_q  <= held_addr_d;
    held_value_q <= held_value_d;
  end

  // Nothing is handed on while the rest of a failed entry is being dropped.
  a_no_job_while_discarding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    discard_q |-> !job_push_o)
    else $error("job pushed while discarding");

  // A short-record error can only come from the final byte of an entry.
  a_size_error_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push_o && job_o.is_error && job_o.err_code == mwrd_pkg::ERR_SIZE
    |-> last_byte_i)
    else $error("size error without last byte");

endmodule

`default_nettype wire

// ===== rtl/core/mwrd_queue.sv =====
// Short job queue between the front and back parts of the decoder.
// Flip-flop storage with a registered head; depends on mwrd_pkg for the job type.
`default_nettype none

module mwrd_queue #(
  parameter int unsigned DEPTH = mwrd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire mwrd_pkg::mwrd_job_t  push_job_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output logic                      head_valid_o,
  output mwrd_pkg::mwrd_job_t       head_job_o
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  mwrd_pkg::mwrd_job_t entry_q [DEPTH];
  logic [IdxW-1:0] wr_ptr_q, wr_ptr_d;
  logic [IdxW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o       = count_q == CntFull;
  assign head_valid_o = count_q != '0;
  assign head_job_o   = entry_q[rd_ptr_q];
  assign do_push      = push_i & ~full_o;
  assign do_pop       = pop_i & head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == IdxLast) ? '0 : wr_ptr_q + IdxW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == IdxLast) ? '0 : rd_ptr_q + IdxW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

  // The front must hold off while the queue is full, or a job is lost.
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job pushed into a full queue");

  // The fill level follows the two pointers.
  a_count_tracks_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 || count_q == CntFull |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with fill level");

endmodule

`default_nettype wire

// ===== rtl/core/mwrd_back.sv =====
// Back part of the decoder: expands each job into condition and write results,
// or an error result, one per cycle unless stalled, into the output register; needs mwrd_pkg.
`default_nettype none

module mwrd_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 job_valid_i,
  input  wire mwrd_pkg::mwrd_job_t  job_i,
  output logic                      job_pop_o,
  input  wire logic                 out_stall_i,
  output logic                      out_valid_o,
  output mwrd_pkg::mwrd_result_t    res_o
);

  logic                    out_valid_q;
  mwrd_pkg::mwrd_result_t  res_q, res_d;
  logic                    cond_done_q, cond_done_d;
  logic [1:0]              lane_q, lane_d;

  logic        load;
  logic        emit;
  logic [1:0]  start;
  logic [2:0]  wr_width;
  logic [2:0]  nxt;
  logic        more;
  logic [31:0] wr_shifted;
  logic [31:0] sel;
  logic        fits;

  assign load       = ~out_valid_q | ~out_stall_i;
  assign emit       = job_valid_i & load;
  assign start      = mwrd_pkg::first_lane(job_i.wr_mask, lane_q);
  assign wr_width   = mwrd_pkg::lane_width(job_i.wr_mask, start);
  assign nxt        = {1'b0, start} + wr_width;
  assign more       = (job_i.wr_mask >> nxt) != 4'd0;
  assign wr_shifted = job_i.wr_value >> {start, 3'b000};
  assign sel        = mwrd_pkg::expand_mask(job_i.cond_mask);
  assign fits       = (job_i.cond_value & ~sel) == 32'd0;

  always_comb begin
    res_d       = '0;
    job_pop_o   = 1'b0;
    cond_done_d = cond_done_q;
    lane_d      = lane_q;

    if (job_i.is_error) begin
      res_d.error_code   = job_i.err_code;
      res_d.entry_done   = 1'b1;
      res_d.record_total = job_i.rec_total;
      res_d.last_result  = 1'b1;
      job_pop_o          = emit;
    end else if (job_i.cond_valid && !cond_done_q) begin
      res_d.op_kind    = job_i.cond_type;
      res_d.cond_span  = mwrd_pkg::count_writes(job_i.wr_mask);
      res_d.op_address = job_i.cond_addr;
      res_d.op_width   = 3'd4;
      res_d.op_value   = job_i.cond_value;
      if (!fits) begin
        res_d.has_mask     = 1'b1;
        res_d.compare_mask = sel;
      end else begin
        case (job_i.cond_mask)
          mwrd_pkg::MASK_LANE0: begin
            res_d.op_width = 3'd1;
            res_d.op_value = {24'd0, job_i.cond_value[7:0]};
          end
          mwrd_pkg::MASK_LANE1: begin
            res_d.op_address = job_i.cond_addr + 28'd1;
            res_d.op_width   = 3'd1;
            res_d.op_value   = {24'd0, job_i.cond_value[15:8]};
          end
          mwrd_pkg::MASK_LANE2: begin
            res_d.op_address = job_i.cond_addr + 28'd2;
            res_d.op_width   = 3'd1;
            res_d.op_value   = {24'd0, job_i.cond_value[23:16]};
          end
          mwrd_pkg::MASK_LANE3: begin
            res_d.op_address = job_i.cond_addr + 28'd3;
            res_d.op_width   = 3'd1;
            res_d.op_value   = {24'd0, job_i.cond_value[31:24]};
          end
          mwrd_pkg::MASK_LOW: begin
            res_d.op_width = 3'd2;
            res_d.op_value = {16'd0, job_i.cond_value[15:0]};
          end
          mwrd_pkg::MASK_HIGH: begin
            res_d.op_address = job_i.cond_addr + 28'd2;
            res_d.op_width   = 3'd2;
            res_d.op_value   = {16'd0, job_i.cond_value[31:16]};
          end
          mwrd_pkg::MASK_FULL: begin
            res_d.op_width = 3'd4;
          end
          default: begin
            res_d.has_mask     = 1'b1;
            res_d.compare_mask = sel;
          end
        endcase
      end
      if (emit) begin
        cond_done_d = 1'b1;
      end
    end else begin
      res_d.op_kind    = mwrd_pkg::OP_WRITE;
      res_d.op_address = job_i.wr_addr + {26'd0, start};
      res_d.op_width   = wr_width;
      case (wr_width)
        3'd1:    res_d.op_value = {24'd0, wr_shifted[7:0]};
        3'd2:    res_d.op_value = {16'd0, wr_shifted[15:0]};
        default: res_d.op_value = wr_shifted;
      endcase
      if (!more) begin
        res_d.last_result = 1'b1;
        if (job_i.final_rec) begin
          res_d.entry_done      = 1'b1;
          res_d.record_total    = job_i.rec_total;
          res_d.compare_warning = job_i.cmp_warn;
        end
        job_pop_o = emit;
        if (emit) begin
          cond_done_d = 1'b0;
          lane_d      = 2'd0;
        end
      end else if (emit) begin
        lane_d = nxt[1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cond_done_q <= 1'b0;
      lane_q      <= 2'd0;
    end else begin
      if (load) begin
        out_valid_q <= job_valid_i;
      end
      cond_done_q <= cond_done_d;
      lane_q      <= lane_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  // A condition is always followed by writes of the same job.
  a_cond_keeps_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !job_i.is_error && job_i.cond_valid && !cond_done_q |-> !job_pop_o)
    else $error("job retired on its condition result");

  // Whatever closes an entry is also the last result of its byte.
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.entry_done |-> res_q.last_result)
    else $error("entry closed before the last result of its byte");

endmodule

`default_nettype wire

// ===== rtl/core/masked_write_record_decoder_top.sv =====
// Top level of the masked write record decoder: front, job queue and back.
// Depends on mwrd_pkg, mwrd_front, mwrd_queue and mwrd_back.
//
//   Beat kind   Direction  Handshake                  Payload
//   ---------   ---------  -------------------------  -------------------------------
//   byte in     input      in_valid_i / in_stall_o    data_byte_i, last_byte_i
//   result out  output     out_valid_o / out_stall_i  op_kind_o .. last_result_o
//
// One input beat is taken every cycle while the job queue has room. A byte
// that completes a write record, or that fails a check, becomes one job; a
// condition record rides in the job of its write. The back turns a job into
// one to three result beats, one per cycle while the output is not stalled;
// its first result passes through the queue and then the output register.
// Reset is asynchronous and active low; it empties the queue and the output
// register and needs no clearing pass, so the block takes a byte right away.
// A stalled output holds its beat; the queue keeps absorbing jobs until it is
// full, and only then is the input stalled.
`default_nettype none

module masked_write_record_decoder_top #(
  parameter int unsigned MAX_RECORDS = mwrd_pkg::MAX_RECORDS_DEF,
  parameter int unsigned QUEUE_DEPTH = mwrd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,

  // Byte channel.
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire logic [7:0]   data_byte_i,
  input  wire logic         last_byte_i,

  // Result channel.
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [2:0]        op_kind_o,
  output logic [27:0]       op_address_o,
  output logic [2:0]        op_width_o,
  output logic [31:0]       op_value_o,
  output logic              has_mask_o,
  output logic [31:0]       compare_mask_o,
  output logic [2:0]        cond_span_o,
  output logic [3:0]        error_code_o,
  output logic              compare_warning_o,
  output logic              entry_done_o,
  output logic [5:0]        record_total_o,
  output logic              last_result_o
);

  // Jobs travel from the front through the queue to the back.
  mwrd_pkg::mwrd_job_t     push_job;
  mwrd_pkg::mwrd_job_t     head_job;
  mwrd_pkg::mwrd_result_t  res;
  logic                    job_push;
  logic                    queue_full;
  logic                    head_valid;
  logic                    job_pop;

  // The front assembles bytes into records, runs the checks in their fixed
  // order and keeps a condition record aside until its write follower comes.
  mwrd_front #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .in_stall_o  (in_stall_o),
    .job_full_i  (queue_full),
    .job_push_o  (job_push),
    .job_o       (push_job)
  );

  // The queue decouples the byte rate from the result rate, so that a
  // stalled consumer does not hold up the link at once.
  mwrd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (job_push),
    .push_job_i   (push_job),
    .full_o       (queue_full),
    .pop_i        (job_pop),
    .head_valid_o (head_valid),
    .head_job_o   (head_job)
  );

  // The back emits the narrowed or masked condition first, then the writes
  // lane by lane, and marks the result that closes the entry.
  mwrd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (head_valid),
    .job_i       (head_job),
    .job_pop_o   (job_pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  assign op_kind_o         = res.op_kind;
  assign op_address_o      = res.op_address;
  assign op_width_o        = res.op_width;
  assign op_value_o        = res.op_value;
  assign has_mask_o        = res.has_mask;
  assign compare_mask_o    = res.compare_mask;
  assign cond_span_o       = res.cond_span;
  assign error_code_o      = res.error_code;
  assign compare_warning_o = res.compare_warning;
  assign entry_done_o      = res.entry_done;
  assign record_total_o    = res.record_total;
  assign last_result_o     = res.last_result;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench of masked_write_record_decoder_top: byte beats in, result beats out.
// Depends on mwrd_pkg for the result type and its codes, and on the RTL of the top level.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mwrd_pkg::*;

  // Condition kinds as carried in the low nibble of the flags word.
  localparam logic [2:0] COND_EQ = 3'd1;
  localparam logic [2:0] COND_NE = 3'd6;

  localparam int HOLDOFF_CYCLES = 150;
  localparam int NUM_ROWS       = 28;

  // One record as it travels on the wire: flags sit in the low word, so byte i
  // of the packed vector is byte i of the little-endian stream.
  typedef struct packed {
    logic [31:0] value;
    logic [31:0] cmp;
    logic [31:0] addr;
    logic [31:0] flags;
  } rec_t;

  // One row of the directed table. A row with typed set also names the error
  // code that its final byte must raise.
  typedef struct packed {
    logic [31:0] flags;
    logic [31:0] addr;
    logic [31:0] cmp;
    logic [31:0] value;
    logic        last;
    logic [4:0]  nbytes;
    logic [5:0]  reps;
    logic [3:0]  want_err;
    logic        typed;
  } row_t;

  // Clock, reset and the driven side of both channels, all known from time zero.
  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic [7:0] data_byte_i = 8'd0;
  logic last_byte_i = 1'b0;
  logic out_stall_i = 1'b0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic [2:0]  op_kind_o;
  logic [27:0] op_address_o;
  logic [2:0]  op_width_o;
  logic [31:0] op_value_o;
  logic        has_mask_o;
  logic [31:0] compare_mask_o;
  logic [2:0]  cond_span_o;
  logic [3:0]  error_code_o;
  logic        compare_warning_o;
  logic        entry_done_o;
  logic [5:0]  record_total_o;
  logic        last_result_o;

  masked_write_record_decoder_top u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .data_byte_i       (data_byte_i),
    .last_byte_i       (last_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .op_kind_o         (op_kind_o),
    .op_address_o      (op_address_o),
    .op_width_o        (op_width_o),
    .op_value_o        (op_value_o),
    .has_mask_o        (has_mask_o),
    .compare_mask_o    (compare_mask_o),
    .cond_span_o       (cond_span_o),
    .error_code_o      (error_code_o),
    .compare_warning_o (compare_warning_o),
    .entry_done_o      (entry_done_o),
    .record_total_o    (record_total_o),
    .last_result_o     (last_result_o)
  );

  // 12 ns period: six high, six low.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder model state. It mirrors what the block must remember between byte
  // beats: the record being assembled, the entry totals and a held condition.
  // ---------------------------------------------------------------------------
  logic [3:0]  rec_pos;
  logic [31:0] flags_acc;
  logic [31:0] addr_acc;
  logic [31:0] value_acc;
  logic        cmp_nonzero;
  logic [5:0]  rec_count;
  logic        cond_held;
  logic [2:0]  cond_kind;
  logic [3:0]  cond_lanes;
  logic [27:0] cond_addr;
  logic [31:0] cond_value;
  logic        cmp_any;
  logic        dropping;

  mwrd_result_t batch[$];        // results of the byte being decoded
  mwrd_result_t pending_ops[$];  // predicted result beats not yet delivered
  mwrd_result_t last_predicted;

  // Run bookkeeping.
  int fail_count     = 0;
  int bytes_sent     = 0;
  int entries_sent   = 0;
  int ops_predicted  = 0;
  int errors_flagged = 0;
  int results_seen   = 0;
  int stalled_cycles = 0;
  int byte_results   = 0;

  // Idling knobs, written by the stimulus and read by the channel processes.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int holdoff_ask   = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    $display("mismatch on %s: got 0x%0h, predicted 0x%0h (result beat %0d, t=%0t)",
             what, got_v, want_v, results_seen, $realtime);
    fail_count++;
  endtask

  function automatic logic [31:0] lanes_to_bits(input logic [3:0] lanes);
    return {{8{lanes[3]}}, {8{lanes[2]}}, {8{lanes[1]}}, {8{lanes[0]}}};
  endfunction

  function automatic mwrd_result_t op_result(input logic [2:0] kind, input logic [27:0] addr,
                                             input logic [2:0] width, input logic [31:0] value,
                                             input logic hm, input logic [31:0] cm,
                                             input logic [2:0] span);
    mwrd_result_t r;
    r              = '0;
    r.op_kind      = kind;
    r.op_address   = addr;
    r.op_width     = width;
    r.op_value     = value;
    r.has_mask     = hm;
    r.compare_mask = cm;
    r.cond_span    = span;
    return r;
  endfunction

  task automatic clear_decoder();
    rec_pos     = '0;
    flags_acc   = '0;
    addr_acc    = '0;
    value_acc   = '0;
    cmp_nonzero = 1'b0;
    rec_count   = '0;
    cond_held   = 1'b0;
    cond_kind   = '0;
    cond_lanes  = '0;
    cond_addr   = '0;
    cond_value  = '0;
    cmp_any     = 1'b0;
    dropping    = 1'b0;
  endtask

  // An error replaces everything the byte produced with one closing beat. The
  // rest of the entry is dropped unless this byte already ended it.
  task automatic flag_error(input logic [3:0] code, input bit lastb);
    mwrd_result_t r;
    r               = '0;
    r.error_code    = code;
    r.entry_done    = 1'b1;
    r.record_total  = rec_count;
    r.last_result   = 1'b1;
    batch.delete();
    batch.push_back(r);
    clear_decoder();
    dropping = !lastb;
  endtask

  // Break a byte-lane mask into aligned writes, lowest lane first: the full
  // mask is one word, an aligned pair is a half word, anything else a byte.
  function automatic void split_writes(input logic [27:0] base, input logic [3:0] lanes,
                                       input logic [31:0] value);
    int lane;
    int w;
    logic [31:0] part;
    lane = 0;
    while (lane < 4) begin
      if (!lanes[lane]) begin
        lane = lane + 1;
      end else begin
        if (lane == 0 && lanes == MASK_FULL) w = 4;
        else if ((lane == 0 || lane == 2) && lanes[lane+1]) w = 2;
        else w = 1;
        part = value >> (lane * 8);
        if (w == 1) part = part & 32'h0000_00FF;
        else if (w == 2) part = part & 32'h0000_FFFF;
        batch.push_back(op_result(OP_WRITE, base + 28'(lane), 3'(w), part, 1'b0, '0, '0));
        lane = lane + w;
      end
    end
  endfunction

  // The held condition becomes a plain compare when its value fits a single
  // byte, an aligned half or the whole word; otherwise it compares under mask.
  function automatic mwrd_result_t cond_result(input logic [2:0] span);
    logic [31:0] sel;
    sel = lanes_to_bits(cond_lanes);
    if ((cond_value & ~sel) == 32'd0) begin
      case (cond_lanes)
        MASK_LANE0: return op_result(cond_kind, cond_addr, 3'd1,
                                     {24'd0, cond_value[7:0]}, 1'b0, '0, span);
        MASK_LANE1: return op_result(cond_kind, cond_addr + 28'd1, 3'd1,
                                     {24'd0, cond_value[15:8]}, 1'b0, '0, span);
        MASK_LANE2: return op_result(cond_kind, cond_addr + 28'd2, 3'd1,
                                     {24'd0, cond_value[23:16]}, 1'b0, '0, span);
        MASK_LANE3: return op_result(cond_kind, cond_addr + 28'd3, 3'd1,
                                     {24'd0, cond_value[31:24]}, 1'b0, '0, span);
        MASK_LOW:   return op_result(cond_kind, cond_addr, 3'd2,
                                     {16'd0, cond_value[15:0]}, 1'b0, '0, span);
        MASK_HIGH:  return op_result(cond_kind, cond_addr + 28'd2, 3'd2,
                                     {16'd0, cond_value[31:16]}, 1'b0, '0, span);
        MASK_FULL:  return op_result(cond_kind, cond_addr, 3'd4, cond_value, 1'b0, '0, span);
        default: ;
      endcase
    end
    return op_result(cond_kind, cond_addr, 3'd4, cond_value, 1'b1, sel, span);
  endfunction

  // Checks of a completed record, in the order the block applies them.
  task automatic close_record(input bit lastb);
    logic [3:0] kind;
    logic [3:0] lanes;
    int span;
    rec_pos = '0;
    if (rec_count >= MAX_RECORDS_DEF) begin
      flag_error(ERR_COUNT, lastb);
      return;
    end
    rec_count = rec_count + 6'd1;
    kind  = flags_acc[3:0];
    lanes = flags_acc[7:4];
    if (flags_acc[31:8] != 24'd0) begin
      flag_error(ERR_RESERVED, lastb);
      return;
    end
    if (kind > TYPE_MAX) begin
      flag_error(ERR_TYPE, lastb);
      return;
    end
    if (lanes == 4'd0) begin
      flag_error(ERR_MASK, lastb);
      return;
    end
    if (addr_acc[31:28] != 4'd0 || addr_acc[1:0] != 2'd0) begin
      flag_error(ERR_ADDRESS, lastb);
      return;
    end
    if (cmp_nonzero) cmp_any = 1'b1;
    cmp_nonzero = 1'b0;

    if (cond_held) begin
      if (kind != 4'(OP_WRITE)) begin
        flag_error(ERR_CHAINED, lastb);
        return;
      end
      split_writes(addr_acc[27:0], lanes, value_acc);
      span = batch.size();
      batch.push_front(cond_result(3'(span)));
      cond_held = 1'b0;
    end else if (kind == 4'(OP_WRITE)) begin
      split_writes(addr_acc[27:0], lanes, value_acc);
    end else begin
      cond_held  = 1'b1;
      cond_kind  = kind[2:0];
      cond_lanes = lanes;
      cond_addr  = addr_acc[27:0];
      cond_value = value_acc;
    end

    if (lastb) begin
      if (cond_held) begin
        flag_error(ERR_NO_FOLLOWER, lastb);
        return;
      end
      if (batch.size() > 0) begin
        batch[batch.size()-1].compare_warning = cmp_any;
        batch[batch.size()-1].entry_done      = 1'b1;
        batch[batch.size()-1].record_total    = rec_count;
      end
      clear_decoder();
    end
    if (batch.size() > 0) batch[batch.size()-1].last_result = 1'b1;
  endtask

  // Predict the result beats of one accepted byte and queue them.
  task automatic decode_byte(input logic [7:0] b, input bit lastb);
    int slot;
    batch.delete();
    if (dropping) begin
      if (lastb) clear_decoder();
    end else begin
      slot = int'(rec_pos[1:0]) * 8;
      case (rec_pos[3:2])
        2'd0: flags_acc[slot +: 8] = b;
        2'd1: addr_acc[slot +: 8]  = b;
        2'd2: if (b != 8'd0) cmp_nonzero = 1'b1;
        default: value_acc[slot +: 8] = b;
      endcase
      if (rec_pos != POS_LAST) begin
        rec_pos = rec_pos + 4'd1;
        if (lastb) flag_error(ERR_SIZE, lastb);
      end else begin
        close_record(lastb);
      end
    end
    byte_results = batch.size();
    foreach (batch[i]) begin
      pending_ops.push_back(batch[i]);
      ops_predicted++;
      if (batch[i].error_code != ERR_NONE) errors_flagged++;
      last_predicted = batch[i];
    end
  endtask

  // ---------------------------------------------------------------------------
  // Byte channel driver. Valid is decided by the sender alone; the payload
  // only changes while valid is low or once the beat has been taken.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input bit lastb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i  <= 1'b0;
      data_byte_i <= 8'($urandom());
      last_byte_i <= 1'($urandom());
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= lastb;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    decode_byte(b, lastb);
    bytes_sent++;
  endtask

  task automatic send_record(input rec_t rc, input int nbytes, input bit lastrec);
    logic [127:0] raw;
    raw = rc;
    for (int i = 0; i < nbytes; i++) begin
      send_byte(raw[i*8 +: 8], lastrec && (i == nbytes - 1));
    end
  endtask

  // Stop offering bytes and let every predicted beat come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_ops.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Random records. Most are well formed so that entries reach conditions and
  // their followers; the rest break one rule or another.
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] rand_addr();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'h0FFF_FFFC;
      default: return $urandom() & 32'h0FFF_FFFC;
    endcase
  endfunction

  function automatic logic [31:0] rand_cmp();
    return ($urandom_range(4) == 0) ? $urandom() : 32'd0;
  endfunction

  function automatic rec_t rand_write();
    rec_t rc;
    rc.flags = {24'd0, 4'($urandom_range(1, 15)), 1'b0, OP_WRITE};
    rc.addr  = rand_addr();
    rc.cmp   = rand_cmp();
    rc.value = $urandom();
    return rc;
  endfunction

  function automatic rec_t rand_cond();
    rec_t rc;
    logic [3:0] lanes;
    lanes    = 4'($urandom_range(1, 15));
    rc.flags = {24'd0, lanes, 1'b0, 3'($urandom_range(COND_EQ, COND_NE))};
    rc.addr  = rand_addr();
    rc.cmp   = rand_cmp();
    rc.value = $urandom();
    // Half the time keep the value inside its lanes so it can be narrowed.
    if ($urandom_range(1) == 0) rc.value = rc.value & lanes_to_bits(lanes);
    return rc;
  endfunction

  function automatic rec_t rand_noise();
    rec_t rc;
    rc = rand_write();
    case ($urandom_range(4))
      0: rc.flags = $urandom();
      1: rc.flags = {24'd0, 8'($urandom())};
      2: rc.addr  = ($urandom_range(1) == 0) ? (rc.addr | (32'h1000_0000 << $urandom_range(3)))
                                             : (rc.addr | 32'($urandom_range(1, 3)));
      3: rc = rand_cond();
      default: rc.flags = {24'd0, 4'd0, 4'($urandom_range(15))};
    endcase
    return rc;
  endfunction

  task automatic random_entry();
    rec_t recs[$];
    int n;
    int pick;
    int cut;
    n = ($urandom_range(9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
    while (recs.size() < n) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        recs.push_back(rand_write());
      end else if (pick < 85) begin
        recs.push_back(rand_cond());
        recs.push_back(rand_write());
      end else begin
        recs.push_back(rand_noise());
      end
    end
    // Now and then the entry ends part way through its final record.
    cut = ($urandom_range(19) == 0) ? $urandom_range(1, 15) : 16;
    foreach (recs[i]) begin
      send_record(recs[i], (i == recs.size() - 1) ? cut : 16, i == recs.size() - 1);
    end
    entries_sent++;
  endtask

  task automatic run_phase(input int snd_pct, input int rcv_pct, input int min_bytes,
                           input int min_ops);
    int b0;
    int o0;
    send_idle_pct = snd_pct;
    stall_pct     = rcv_pct;
    b0 = bytes_sent;
    o0 = ops_predicted;
    while (bytes_sent - b0 < min_bytes || ops_predicted - o0 < min_ops) random_entry();
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Result channel: the stall is random, except during a requested hold-off,
  // which is counted out here in cycles of its own.
  // ---------------------------------------------------------------------------
  int holdoff_seen = 0;
  int holdoff_left = 0;

  always @(posedge clk_i) begin
    if (holdoff_seen != holdoff_ask) begin
      holdoff_seen = holdoff_ask;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left != 0) begin
      holdoff_left = holdoff_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compare one delivered beat, field by field, with the oldest prediction.
  task automatic check_result();
    mwrd_result_t got;
    mwrd_result_t want;
    got.op_kind         = op_kind_o;
    got.op_address      = op_address_o;
    got.op_width        = op_width_o;
    got.op_value        = op_value_o;
    got.has_mask        = has_mask_o;
    got.compare_mask    = compare_mask_o;
    got.cond_span       = cond_span_o;
    got.error_code      = error_code_o;
    got.compare_warning = compare_warning_o;
    got.entry_done      = entry_done_o;
    got.record_total    = record_total_o;
    got.last_result     = last_result_o;
    if (pending_ops.size() == 0) begin
      report_mismatch("result beat with nothing pending", 32'(got.op_address), 32'd0);
    end else begin
      want = pending_ops.pop_front();
      if (got.op_kind !== want.op_kind)
        report_mismatch("op_kind", 32'(got.op_kind), 32'(want.op_kind));
      if (got.op_address !== want.op_address)
        report_mismatch("op_address", 32'(got.op_address), 32'(want.op_address));
      if (got.op_width !== want.op_width)
        report_mismatch("op_width", 32'(got.op_width), 32'(want.op_width));
      if (got.op_value !== want.op_value)
        report_mismatch("op_value", got.op_value, want.op_value);
      if (got.has_mask !== want.has_mask)
        report_mismatch("has_mask", 32'(got.has_mask), 32'(want.has_mask));
      if (got.compare_mask !== want.compare_mask)
        report_mismatch("compare_mask", got.compare_mask, want.compare_mask);
      if (got.cond_span !== want.cond_span)
        report_mismatch("cond_span", 32'(got.cond_span), 32'(want.cond_span));
      if (got.error_code !== want.error_code)
        report_mismatch("error_code", 32'(got.error_code), 32'(want.error_code));
      if (got.compare_warning !== want.compare_warning)
        report_mismatch("compare_warning", 32'(got.compare_warning),
                        32'(want.compare_warning));
      if (got.entry_done !== want.entry_done)
        report_mismatch("entry_done", 32'(got.entry_done), 32'(want.entry_done));
      if (got.record_total !== want.record_total)
        report_mismatch("record_total", 32'(got.record_total), 32'(want.record_total));
      if (got.last_result !== want.last_result)
        report_mismatch("last_result", 32'(got.last_result), 32'(want.last_result));
    end
    results_seen++;
  endtask

  // Sample both channels on the rising edge, where every driven value is
  // settled from the previous step.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_stall_o) stalled_cycles++;
      if (out_valid_o && !out_stall_i) check_result();
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table. Columns: flags, address, compare, value, last, bytes sent,
  // repeats, error code, and whether that code is typed in here. The low flag
  // nibble is the kind and the next nibble the byte-lane mask.
  // ---------------------------------------------------------------------------
  row_t dir_rows [NUM_ROWS];

  initial begin
    dir_rows = '{
      // Full-word writes at both ends of the address and value ranges.
      '{32'h0000_00F0, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 5'd16, 6'd1, ERR_NONE, 1'b0},
      '{32'h0000_00F0, 32'h0FFF_FFFC, 32'h0000_0000, 32'h0000_0000, 1'b1, 5'd16, 6'd1, ERR_NONE, 1'b0},
      // Two lone bytes, with a nonzero compare word to raise the warning.
      '{32'h0000_0050, 32'h0000_1230, 32'h0000_0001, 32'hA5C3_5A3C, 1'b1, 5'd16, 6'd1, ERR_NONE, 1'b0},
      // Condition kinds one to four, each held and then released by its write.
      '{32'h0000_0011, 32'h0000_0100, 32'h0000_0000, 32'h0000_0042, 1'b0, 5'd16, 6'd1, ERR_NONE, 1'b0},
      '{32'h0000_0030, 32'h0000_0200, 32'h0000_0000, 32'h1234_5678, 1'b1, 5'd16, 6'd1, ERR_NONE, 1'b0},
      '{32'h0000_0032, 32'h0000_0104, 32'h0000_0000, 32'h0000_BEEF, 1'b0, 5'd16, 6'd1, ERR_NONE, 1'b0},
      '{32'h0000_00C0, 32'h0000_0204, 32'h0000_0000, 32'h89AB_CDEF, 1'b1, 5'd16, 6'd1, ERR_NONE, 1'b0},
      '{32'h0000_00C3, 32'h0000_0108, 32'h0000_0000, 32'hABCD_0000, 1'b0, 5'd16, 6'd1, ERR_NONE, 1'b0},
      '{32'h0000_00A0, 32'h0000_0208, 32'h0000_0000, 32'h0102_0304, 1'b1, 5'd16, 6'd1, ERR_NONE, 1'b0},
      '{32'h0000_00F4, 32'h0000_010C, 32'h0000_0000, 32'h8000_0001, 1'b0, 5'd16, 6'd1, ERR_NONE, 1'b0},
      '{32'h0000_0090, 32'h0000_020C, 32'hFFFF_FFFF, 32'hFEDC_BA98, 1'b1, 5'd16, 6'd1, ERR_NONE, 1'b0},
      // Middle lanes cannot be narrowed, so this one compares under mask.
      '{32'h0000_0065, 32'h0000_0110, 32'h0000_0000, 32'h00FF_FF00, 1'b0, 5'd16, 6'd1, ERR_NONE, 1'b0},
      '{32'h0000_00E0, 32'h0000_0210, 32'h0000_0000, 32'h55AA_55AA, 1'b1, 5'd16, 6'd1, ERR_NONE, 1'b0},
      // A single lane whose value spills outside it also falls back to a mask.
      '{32'h0000_0016, 32'h0000_0114, 32'h0000_0000, 32'h0000_1234, 1'b0, 5'd16, 6'd1, ERR_NONE, 1'b0},
      '{32'h0000_0070, 32'h0000_0214, 32'h0000_0000, 32'hCAFE_F00D, 1'b1, 5'd16, 6'd1, ERR_NONE, 1'b0},
      '{32'h0000_0081, 32'h0000_0118, 32'h0000_0000, 32'h5A00_0000, 1'b0, 5'd16, 6'd1, ERR_NONE, 1'b0},
      '{32'h0000_00D0, 32'h0000_0218, 32'h0000_0000, 32'h1122_3344, 1'b1, 5'd16, 6'd1, ERR_NONE, 1'b0},
      // Reserved flag bits, a kind above the last one, an empty lane mask.
      '{32'h0000_0100, 32'h0000_0300, 32'h0000_0000, 32'h0000_0000, 1'b1, 5'd16, 6'd1, ERR_RESERVED, 1'b1},
      '{32'h0000_0017, 32'h0000_0300, 32'h0000_0000, 32'h0000_0000, 1'b1, 5'd16, 6'd1, ERR_TYPE, 1'b1},
      '{32'h0000_0000, 32'h0000_0300, 32'h0000_0000, 32'h0000_0000, 1'b1, 5'd16, 6'd1, ERR_MASK, 1'b1},
      // Address beyond 28 bits; then a misaligned one mid-entry, whose
      // follower must be swallowed up to the last byte.
      '{32'h0000_0010, 32'h1000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 5'd16, 6'd1, ERR_ADDRESS, 1'b1},
      '{32'h0000_0010, 32'h0000_0102, 32'h0000_0000, 32'h0000_0000, 1'b0, 5'd16, 6'd1, ERR_ADDRESS, 1'b1},
      '{32'h0000_0010, 32'h0000_0300, 32'h0000_0000, 32'h0000_00AA, 1'b1, 5'd16, 6'd1, ERR_NONE, 1'b0},
      // A condition that closes the entry, then a condition chained on another.
      '{32'h0000_0021, 32'h0000_0400, 32'h0000_0000, 32'h0000_3300, 1'b1, 5'd16, 6'd1, ERR_NO_FOLLOWER, 1'b1},
      '{32'h0000_0021, 32'h0000_0400, 32'h0000_0000, 32'h0000_3300, 1'b0, 5'd16, 6'd1, ERR_NONE, 1'b0},
      '{32'h0000_0032, 32'h0000_0404, 32'h0000_0000, 32'h0000_7777, 1'b1, 5'd16, 6'd1, ERR_CHAINED, 1'b1},
      // Payload cut short, and one record more than an entry may carry.
      '{32'h0000_0010, 32'h0000_0500, 32'h0000_0000, 32'h0000_0000, 1'b1, 5'd5,  6'd1, ERR_SIZE, 1'b1},
      '{32'h0000_0010, 32'h0000_0600, 32'h0000_0000, 32'h0000_00EE, 1'b1, 5'd16, 6'd33, ERR_COUNT, 1'b1}
    };
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, a long receiver hold-off while the
  // sender keeps offering bytes, then random entries under each idling mix.
  // Every phase ends with the sender pausing until all beats are back.
  // ---------------------------------------------------------------------------
  initial begin
    rec_t rc;
    clear_decoder();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 10;
    stall_pct     = 10;
    foreach (dir_rows[i]) begin
      rc = '{value: dir_rows[i].value, cmp: dir_rows[i].cmp,
             addr: dir_rows[i].addr, flags: dir_rows[i].flags};
      for (int r = 0; r < int'(dir_rows[i].reps); r++) begin
        send_record(rc, int'(dir_rows[i].nbytes),
                    dir_rows[i].last && (r == int'(dir_rows[i].reps) - 1));
      end
      // The typed code is held against the model's own answer for the row.
      if (dir_rows[i].typed) begin
        if (byte_results == 0)
          report_mismatch("typed error row gave no beat", 32'(i), 32'(dir_rows[i].want_err));
        else if (last_predicted.error_code !== dir_rows[i].want_err)
          report_mismatch("typed error code", 32'(last_predicted.error_code),
                          32'(dir_rows[i].want_err));
      end
      entries_sent += dir_rows[i].last ? 1 : 0;
    end
    wait_drained();

    // The output stays stalled long enough for the job queue to fill and the
    // byte channel to be held off.
    holdoff_ask++;
    run_phase(0, 0, 160, 0);

    run_phase(0, 0, 65, 15);
    run_phase(48, 0, 65, 15);
    run_phase(0, 48, 65, 15);
    run_phase(35, 35, 65, 15);

    // Give a stray late beat the chance to show itself.
    repeat (16) @(posedge clk_i);
    if (pending_ops.size() != 0)
      report_mismatch("result beats never delivered", 32'(pending_ops.size()), 32'd0);

    $display("Covered %0d bytes in %0d entries, %0d result beats (%0d flagging errors).",
             bytes_sent, entries_sent, results_seen, errors_flagged);
    $display("Byte channel held off for %0d cycles; %0d mismatches counted.",
             stalled_cycles, fail_count);
    if (fail_count == 0) begin
      $display("masked_write_record_decoder_top regression: pass");
    end else begin
      $display("masked_write_record_decoder_top regression: fail");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("masked_write_record_decoder_top regression: fail");
    $finish;
  end

endmodule
